### src/llkc_pkg.sv
`timescale 1ns / 1ps

package llkc_pkg;

  localparam int unsigned MAX_LINE_CHARS_DEF = 2047;
  localparam int unsigned COUNT_WIDTH_DEF    = 32;

  localparam int unsigned NUM_KW     = 12;
  localparam int unsigned NUM_RULES  = 7;
  localparam int unsigned HIST_BYTES = 7;
  localparam int unsigned WIN_BITS   = 8 * (HIST_BYTES + 1);

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_CASE    = 8'h20;

  // keyword text right-aligned, last character in the low byte
  localparam logic [WIN_BITS-1:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0069_3263,  // i2c
    64'h0000_0000_7265_6164,  // read
    64'h0000_0000_6661_696C,  // fail
    64'h0000_0070_726F_6265,  // probe
    64'h0000_0000_0063_7369,  // csi
    64'h0074_696D_656F_7574,  // timeout
    64'h0000_7374_7265_616D,  // stream
    64'h0000_0063_6C6F_636B,  // clock
    64'h0000_666F_726D_6174,  // format
    64'h6D69_736D_6174_6368,  // mismatch
    64'h0000_7365_6E73_6F72,  // sensor
    64'h0000_0000_0000_6964   // id
  };

  localparam logic [WIN_BITS-1:0] KW_MASK [NUM_KW] = '{
    64'h0000_0000_00FF_FFFF,
    64'h0000_0000_FFFF_FFFF,
    64'h0000_0000_FFFF_FFFF,
    64'h0000_00FF_FFFF_FFFF,
    64'h0000_0000_00FF_FFFF,
    64'h00FF_FFFF_FFFF_FFFF,
    64'h0000_FFFF_FFFF_FFFF,
    64'h0000_00FF_FFFF_FFFF,
    64'h0000_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_FFFF
  };

  // keyword bit order: i2c read fail probe csi timeout stream clock
  //                    format mismatch sensor id
  localparam logic [NUM_KW-1:0] RULE_MASK [NUM_RULES] = '{
    12'b0000_0000_0111,
    12'b0000_0000_1100,
    12'b0000_0011_0000,
    12'b0000_0110_0000,
    12'b0000_1000_0100,
    12'b0011_0000_0000,
    12'b1100_0000_0000
  };

  typedef enum logic [2:0] {
    CLS_I2C_READ       = 3'd0,
    CLS_PROBE          = 3'd1,
    CLS_CSI_TIMEOUT    = 3'd2,
    CLS_STREAM_TIMEOUT = 3'd3,
    CLS_CLOCK          = 3'd4,
    CLS_FORMAT         = 3'd5,
    CLS_SENSOR_ID      = 3'd6,
    CLS_NONE           = 3'd7
  } class_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic   valid;
    class_e cls;
  } line_ev_t;

endpackage

### src/llkc_in_if.sv
`timescale 1ns / 1ps

interface llkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       stream_end;

  modport source (output valid, output text_byte, output stream_end, input ready);
  modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

### src/llkc_out_if.sv
`timescale 1ns / 1ps

interface llkc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  issue_class;
  logic [31:0] class_total;
  logic [31:0] lines_total;
  logic [31:0] matched_total;

  modport source (output valid, output issue_class, output class_total,
                  output lines_total, output matched_total, input ready);
  modport sink   (input valid, input issue_class, input class_total,
                  input lines_total, input matched_total, output ready);
endinterface

### src/llkc_byte_cell.sv
`timescale 1ns / 1ps

module llkc_byte_cell
  import llkc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.clear) begin
      byte_d = '0;
    end else if (ctl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

### src/llkc_line_tracker.sv
`timescale 1ns / 1ps

module llkc_line_tracker
  import llkc_pkg::*;
#(
  parameter int unsigned MAX_LINE_CHARS = MAX_LINE_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_byte_i,
  input  logic       stream_end_i,
  input  logic [7:0] hist_i [HIST_BYTES],
  output logic [7:0] fold_o,
  output cell_ctl_t  cell_ctl_o,
  output line_ev_t   ev_o
);

  localparam int unsigned LEN_W = $clog2(MAX_LINE_CHARS);

  logic [NUM_KW-1:0] seen_q, seen_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              zero_q, zero_d;
  line_ev_t          ev_q, ev_d;

  logic [7:0]          fold;
  logic [WIN_BITS-1:0] win;
  logic                zero_now;
  logic [NUM_KW-1:0]   hits;
  logic [NUM_KW-1:0]   seen_next;
  logic                line_end;
  class_e              cls;

  // lower-case fold
  always_comb begin
    fold = text_byte_i;
    if (text_byte_i >= CHAR_UPPER_A && text_byte_i <= CHAR_UPPER_Z) begin
      fold = text_byte_i | CHAR_CASE;
    end
  end

  always_comb begin
    win[7:0] = fold;
    for (int k = 0; k < HIST_BYTES; k++) begin
      win[8*(k+1) +: 8] = hist_i[k];
    end
  end

  assign zero_now = zero_q || (fold == 8'h00);

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      hits[k] = !zero_now && ((win & KW_MASK[k]) == KW_TEXT[k]);
    end
  end

  assign seen_next = seen_q | hits;
  assign line_end  = (fold == CHAR_NEWLINE) || stream_end_i ||
                     (len_q == LEN_W'(MAX_LINE_CHARS - 1));

  // first rule that holds wins
  always_comb begin
    cls = CLS_NONE;
    for (int r = NUM_RULES - 1; r >= 0; r--) begin
      if ((seen_next & RULE_MASK[r]) == RULE_MASK[r]) begin
        cls = class_e'(3'(r));
      end
    end
  end

  always_comb begin
    seen_d   = seen_q;
    len_d    = len_q;
    zero_d   = zero_q;
    ev_d     = '{valid: 1'b0, cls: cls};
    if (accept_i) begin
      if (line_end) begin
        seen_d     = '0;
        len_d      = '0;
        zero_d     = 1'b0;
        ev_d.valid = 1'b1;
      end else begin
        seen_d = seen_next;
        len_d  = len_q + 1'b1;
        zero_d = zero_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      len_q  <= '0;
      zero_q <= 1'b0;
      ev_q   <= '{valid: 1'b0, cls: CLS_NONE};
    end else begin
      seen_q <= seen_d;
      len_q  <= len_d;
      zero_q <= zero_d;
      ev_q   <= ev_d;
    end
  end

  assign fold_o     = fold;
  assign cell_ctl_o = '{shift: accept_i, clear: accept_i && line_end};
  assign ev_o       = ev_q;

endmodule

### src/llkc_tally.sv
`timescale 1ns / 1ps

module llkc_tally
  import llkc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  line_ev_t ev_i,
  output logic     room_o,
  llkc_out_if.source res_o
);

  localparam int unsigned DEPTH = 3;

  typedef struct packed {
    class_e      issue_class;
    logic [31:0] class_total;
    logic [31:0] lines_total;
    logic [31:0] matched_total;
  } result_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  logic [COUNT_WIDTH-1:0] line_q, line_d;
  logic [COUNT_WIDTH-1:0] match_q, match_d;
  logic [COUNT_WIDTH-1:0] cls_cnt_q [NUM_RULES];
  logic [COUNT_WIDTH-1:0] cls_inc;
  logic                   hit;

  result_t    mem_q [DEPTH];
  result_t    res;
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign hit     = ev_i.valid && (ev_i.cls != CLS_NONE);
  assign cls_inc = (ev_i.cls != CLS_NONE) ? sat_inc(cls_cnt_q[ev_i.cls]) : '0;

  always_comb begin
    line_d  = line_q;
    match_d = match_q;
    if (ev_i.valid) begin
      line_d = sat_inc(line_q);
    end
    if (hit) begin
      match_d = sat_inc(match_q);
    end
  end

  always_comb begin
    res.issue_class   = ev_i.cls;
    res.class_total   = 32'(cls_inc);
    res.lines_total   = 32'(line_d);
    res.matched_total = 32'(match_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= '0;
      match_q <= '0;
      for (int r = 0; r < NUM_RULES; r++) begin
        cls_cnt_q[r] <= '0;
      end
    end else begin
      line_q  <= line_d;
      match_q <= match_d;
      for (int r = 0; r < NUM_RULES; r++) begin
        if (hit && (ev_i.cls == class_e'(3'(r)))) begin
          cls_cnt_q[r] <= cls_inc;
        end
      end
    end
  end

  // three-entry result queue
  assign push = ev_i.valid;
  assign pop  = res_o.valid && res_o.ready;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == 2'(DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
    end
    if (pop) begin
      rd_d = (rd_q == 2'(DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= res;
    end
  end

  // queue entries plus the one in flight must leave a slot free
  assign room_o = ({1'b0, cnt_q} + {2'b00, ev_i.valid}) < 3'(DEPTH);

  assign res_o.valid         = (cnt_q != 2'd0);
  assign res_o.issue_class   = mem_q[rd_q].issue_class;
  assign res_o.class_total   = mem_q[rd_q].class_total;
  assign res_o.lines_total   = mem_q[rd_q].lines_total;
  assign res_o.matched_total = mem_q[rd_q].matched_total;

endmodule

### src/log_line_keyword_classifier_unit.sv
`timescale 1ns / 1ps

// log line keyword classifier
// req_i carries one log byte per request (text_byte, stream_end flags the
// final byte of the log). res_o carries one result per line chunk: the class
// of the first keyword rule that holds (7 when none), that class's count, and
// the line and match counts, all saturating and shown as their low 32 bits.
// A chunk ends on a newline, on its MAX_LINE_CHARS-th byte or on stream_end.
// throughput: one byte per cycle while req_i.ready is high, set by the
// seven-cell byte history chain that shifts on every accepted request while
// the window is compared against all twelve keywords at once.
// the closing request's event is registered in the line tracker, then the
// counters and the queue entry are registered before the result is offered.
// results wait in a three-entry queue; while the receiver stalls, req_i.ready
// stays high until the queue and the line tracker's event register together
// hold three results, so bytes that close no line keep flowing meanwhile.
// reset clears the history, the keyword flags, the chunk state, all counters
// and the queue; the block takes requests as soon as reset is released.
module log_line_keyword_classifier_unit
  import llkc_pkg::*;
#(
  parameter int unsigned MAX_LINE_CHARS = MAX_LINE_CHARS_DEF,
  parameter int unsigned COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  llkc_in_if.sink    req_i,
  llkc_out_if.source res_o
);

  logic       accept;
  logic       room;
  logic [7:0] fold;
  cell_ctl_t  cell_ctl;
  line_ev_t   ev;

  // history chain, cell 0 holds the byte just before the current one
  logic [7:0] hist [HIST_BYTES];

  assign req_i.ready = room;
  assign accept      = req_i.valid && room;

  // per-line keyword flags, chunk length and zero-byte mask
  llkc_line_tracker #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (req_i.text_byte),
    .stream_end_i (req_i.stream_end),
    .hist_i       (hist),
    .fold_o       (fold),
    .cell_ctl_o   (cell_ctl),
    .ev_o         (ev)
  );

  // each cell hands its byte to the next one on every accepted request,
  // and the whole row clears at a chunk end
  for (genvar k = 0; k < HIST_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      llkc_byte_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (cell_ctl),
        .byte_i (fold),
        .byte_o (hist[k])
      );
    end else begin : g_body
      llkc_byte_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (cell_ctl),
        .byte_i (hist[k-1]),
        .byte_o (hist[k])
      );
    end
  end

  // counters and result queue
  llkc_tally #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tally (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ev_i   (ev),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule
